[design/xor_float_delta_compressor_top_macros.svh]
// Assertion macros for the XOR float delta compressor.
`ifndef XOR_FLOAT_DELTA_COMPRESSOR_TOP_MACROS_SVH
`define XOR_FLOAT_DELTA_COMPRESSOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define XFDC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xfdc assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define XFDC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xfdc assertion failed");

`endif

[design/xfdc_pkg.sv]
// Shared constants and types for the XOR float delta compressor.
package xfdc_pkg;

    localparam int WORD_BITS  = 32;
    localparam int LEAD_BITS  = 5;
    localparam int NLEN_BITS  = 6;
    localparam int CHUNK_BITS = 45;
    localparam int CNT_BITS   = 6;

    localparam logic [1:0] KIND_RAW   = 2'd0;
    localparam logic [1:0] KIND_ZERO  = 2'd1;
    localparam logic [1:0] KIND_REUSE = 2'd2;
    localparam logic [1:0] KIND_NEW   = 2'd3;

    localparam logic [1:0] CTRL_REUSE = 2'b10;
    localparam logic [1:0] CTRL_NEW   = 2'b11;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef struct packed {
        logic [WORD_BITS-1:0] prev_word;
        logic [CNT_BITS-1:0]  prev_lead;
        logic [CNT_BITS-1:0]  prev_trail;
        logic                 seen_any;
        logic                 seen_two;
    } t_hist;

    typedef struct packed {
        logic [CHUNK_BITS-1:0] chunk;
        logic [NLEN_BITS-1:0]  length;
        logic [1:0]            kind;
    } t_code;

endpackage

[design/xfdc_zcount.sv]
// Leading and trailing zero counts of a 32-bit word, log-depth search.
module xfdc_zcount (
    input  logic [xfdc_pkg::WORD_BITS-1:0] i_word,
    output logic [xfdc_pkg::CNT_BITS-1:0]  o_lead,
    output logic [xfdc_pkg::CNT_BITS-1:0]  o_trail
);

    function automatic logic [xfdc_pkg::CNT_BITS-1:0] clz(
        input logic [xfdc_pkg::WORD_BITS-1:0] v_in
    );
        logic [xfdc_pkg::WORD_BITS-1:0] v;
        logic [xfdc_pkg::CNT_BITS-1:0]  n;
        v = v_in;
        n = '0;
        for (int s = 4; s >= 0; s--) begin
            if ((v >> (xfdc_pkg::WORD_BITS - (1 << s))) == '0) begin
                n = n + xfdc_pkg::CNT_BITS'(1 << s);
                v = v << (1 << s);
            end
        end
        if (!v[xfdc_pkg::WORD_BITS-1]) begin
            n = n + xfdc_pkg::CNT_BITS'(1);
        end
        return n;
    endfunction

    logic [xfdc_pkg::WORD_BITS-1:0] rev_word;

    always_comb begin
        for (int i = 0; i < xfdc_pkg::WORD_BITS; i++) begin
            rev_word[i] = i_word[xfdc_pkg::WORD_BITS-1-i];
        end
    end

    assign o_lead  = clz(i_word);
    assign o_trail = clz(rev_word);

endmodule

[design/xfdc_encoder.sv]
// Per-word code selection and chunk assembly.
module xfdc_encoder (
    input  logic [xfdc_pkg::WORD_BITS-1:0] i_word,
    input  xfdc_pkg::t_hist                i_hist,
    output xfdc_pkg::t_code                o_code,
    output logic [xfdc_pkg::CNT_BITS-1:0]  o_lead,
    output logic [xfdc_pkg::CNT_BITS-1:0]  o_trail
);

    localparam int HDR_BITS = 2 + xfdc_pkg::LEAD_BITS + xfdc_pkg::NLEN_BITS;

    logic [xfdc_pkg::WORD_BITS-1:0]  x;
    logic [xfdc_pkg::CNT_BITS-1:0]   lead;
    logic [xfdc_pkg::CNT_BITS-1:0]   trail;
    logic                            reuse;
    logic [xfdc_pkg::NLEN_BITS-1:0]  n_bits;
    logic [xfdc_pkg::CNT_BITS-1:0]   shift;
    logic [xfdc_pkg::CHUNK_BITS-1:0] hdr;

    assign x = i_word ^ i_hist.prev_word;

    xfdc_zcount u_zcount (
        .i_word  (x),
        .o_lead  (lead),
        .o_trail (trail)
    );

    assign reuse = i_hist.seen_two && (lead >= i_hist.prev_lead)
                 && (trail == i_hist.prev_trail);

    always_comb begin
        if (reuse) begin
            n_bits = xfdc_pkg::NLEN_BITS'(xfdc_pkg::WORD_BITS) - i_hist.prev_lead
                   - i_hist.prev_trail;
            shift  = i_hist.prev_trail;
            hdr    = xfdc_pkg::CHUNK_BITS'(xfdc_pkg::CTRL_REUSE);
        end else begin
            n_bits = xfdc_pkg::NLEN_BITS'(xfdc_pkg::WORD_BITS) - lead - trail;
            shift  = trail;
            hdr    = xfdc_pkg::CHUNK_BITS'({xfdc_pkg::CTRL_NEW,
                                            lead[xfdc_pkg::LEAD_BITS-1:0], n_bits});
        end
    end

    always_comb begin
        if (!i_hist.seen_any) begin
            o_code.chunk  = xfdc_pkg::CHUNK_BITS'(i_word);
            o_code.length = xfdc_pkg::NLEN_BITS'(xfdc_pkg::WORD_BITS);
            o_code.kind   = xfdc_pkg::KIND_RAW;
        end else if (x == '0) begin
            o_code.chunk  = '0;
            o_code.length = xfdc_pkg::NLEN_BITS'(1);
            o_code.kind   = xfdc_pkg::KIND_ZERO;
        end else if (reuse) begin
            o_code.chunk  = (hdr << n_bits) | xfdc_pkg::CHUNK_BITS'(x >> shift);
            o_code.length = xfdc_pkg::NLEN_BITS'(2) + n_bits;
            o_code.kind   = xfdc_pkg::KIND_REUSE;
        end else begin
            o_code.chunk  = (hdr << n_bits) | xfdc_pkg::CHUNK_BITS'(x >> shift);
            o_code.length = xfdc_pkg::NLEN_BITS'(HDR_BITS) + n_bits;
            o_code.kind   = xfdc_pkg::KIND_NEW;
        end
    end

    // stored as the window of the next word; first word leaves x == word
    assign o_lead  = lead;
    assign o_trail = trail;

endmodule

[design/xor_float_delta_compressor_top.sv]
// Top level of the XOR float delta compressor: input register, encoder, result register.
// A word accepted into the input register reaches the output once the result register takes its code chunk.
// Throughput: one word per cycle while i_out_ready is high; the input register feeds the result register
// through the encoder, and history updates as a word enters the result register.
// Reset: synchronous, active low; clears valids, previous word and the word count,
// and sets the window counts to 32, so the next word is sent raw.
module xor_float_delta_compressor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [xfdc_pkg::WORD_BITS-1:0]  i_value_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [xfdc_pkg::CHUNK_BITS-1:0] o_code_chunk,
    output logic [xfdc_pkg::NLEN_BITS-1:0]  o_code_length,
    output logic [1:0]                      o_code_kind
);

    logic                           r_a_valid;
    logic [xfdc_pkg::WORD_BITS-1:0] r_a_word;
    logic                           r_b_valid;
    xfdc_pkg::t_code                r_b_code;

    logic [xfdc_pkg::WORD_BITS-1:0] r_prev_word;
    logic [xfdc_pkg::CNT_BITS-1:0]  r_prev_lead;
    logic [xfdc_pkg::CNT_BITS-1:0]  r_prev_trail;
    logic [1:0]                     r_seen_cnt;
    logic [1:0]                     n_seen_cnt;

    xfdc_pkg::t_hist                hist;
    xfdc_pkg::t_code                code;
    logic [xfdc_pkg::CNT_BITS-1:0]  x_lead;
    logic [xfdc_pkg::CNT_BITS-1:0]  x_trail;
    logic                           b_take;
    logic                           in_take;

    assign b_take     = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || b_take;
    assign in_take    = i_in_valid && o_in_ready;

    assign hist.prev_word  = r_prev_word;
    assign hist.prev_lead  = r_prev_lead;
    assign hist.prev_trail = r_prev_trail;
    assign hist.seen_any   = (r_seen_cnt != xfdc_pkg::SEEN_NONE);
    assign hist.seen_two   = (r_seen_cnt == xfdc_pkg::SEEN_TWO);

    assign n_seen_cnt = (r_seen_cnt == xfdc_pkg::SEEN_NONE) ? xfdc_pkg::SEEN_ONE
                                                            : xfdc_pkg::SEEN_TWO;

    xfdc_encoder u_encoder (
        .i_word  (r_a_word),
        .i_hist  (hist),
        .o_code  (code),
        .o_lead  (x_lead),
        .o_trail (x_trail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_prev_word  <= '0;
            r_prev_lead  <= xfdc_pkg::CNT_BITS'(xfdc_pkg::WORD_BITS);
            r_prev_trail <= xfdc_pkg::CNT_BITS'(xfdc_pkg::WORD_BITS);
            r_seen_cnt   <= xfdc_pkg::SEEN_NONE;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_take) begin
                r_b_valid    <= 1'b1;
                r_prev_word  <= r_a_word;
                r_prev_lead  <= x_lead;
                r_prev_trail <= x_trail;
                r_seen_cnt   <= n_seen_cnt;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_word <= i_value_word;
        end
        if (b_take) begin
            r_b_code <= code;
        end
    end

    assign o_out_valid   = r_b_valid;
    assign o_code_chunk  = r_b_code.chunk;
    assign o_code_length = r_b_code.length;
    assign o_code_kind   = r_b_code.kind;

`include "xor_float_delta_compressor_top_macros.svh"

    `XFDC_ASSERT_NOW(a_zero_code, o_out_valid && (o_code_kind == xfdc_pkg::KIND_ZERO), (o_code_length == 6'd1) && (o_code_chunk == '0))
    `XFDC_ASSERT_NOW(a_raw_first, o_out_valid && (o_code_kind == xfdc_pkg::KIND_RAW), r_seen_cnt == xfdc_pkg::SEEN_ONE)
    `XFDC_ASSERT_NOW(a_reuse_len, o_out_valid && (o_code_kind == xfdc_pkg::KIND_REUSE), (r_seen_cnt == xfdc_pkg::SEEN_TWO) && (o_code_length >= 6'd3) && (o_code_length <= 6'd34))
    `XFDC_ASSERT_NOW(a_new_len, o_out_valid && (o_code_kind == xfdc_pkg::KIND_NEW), (o_code_length >= 6'd14) && (o_code_length <= 6'd45))
    `XFDC_ASSERT_NEXT(a_hist_step, b_take && (r_seen_cnt != xfdc_pkg::SEEN_NONE), r_seen_cnt == xfdc_pkg::SEEN_TWO)

endmodule
